// ===== hw/rtl/mhrt_pkg.sv =====
// Shared types and codes for the max-heap rebuild and traverse block.
// Used by max_heap_rebuild_and_traverse; no dependencies.
package mhrt_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_SN,
    S_SL,
    S_SR,
    S_SC,
    S_SW1,
    S_SW2,
    S_WNODE,
    S_WDATA,
    S_FLUSH,
    S_RESP
  } state_t;

  // Traversal order codes
  typedef enum logic [1:0] {
    ORD_IN    = 2'd0,
    ORD_PRE   = 2'd1,
    ORD_POST  = 2'd2,
    ORD_ARRAY = 2'd3
  } order_t;

  // Result kind codes
  typedef enum logic [1:0] {
    K_INS   = 2'd0,
    K_OVF   = 2'd1,
    K_ENT   = 2'd2,
    K_EMPTY = 2'd3
  } kind_t;

  // Walk direction: arriving from parent, back from left, back from right
  typedef enum logic [1:0] {
    D_DOWN  = 2'd0,
    D_LEFT  = 2'd1,
    D_RIGHT = 2'd2
  } dir_t;

  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int ENT_W = KEY_W + PAY_W;
  localparam int POS_W = 6;
  localparam int FUNC_INSERT = 0;

endpackage

// ===== hw/rtl/mhrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhrt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/max_heap_rebuild_and_traverse.sv =====
// Top level of the array-backed max-heap with traversal read-out.
// Depends on mhrt_pkg and mhrt_ram.
//
// Usage:
//   Input stream s_axis: one transfer is one command. tuser[0] selects insert
//   (0) or traverse (1), tuser[2:1] the traversal order. tdata carries the key
//   (bits 31:0, signed) and payload (bits 63:32) of an inserted entry.
//   Output stream m_axis: tuser is the result kind, tdata holds key, payload
//   and array slot, tlast marks the final result of a command.
//   An insert gives one result; a traverse gives one result per stored entry
//   (or one empty marker), in the requested order.
// Sequencing:
//   s_axis_tready is high only while the sequencer is idle. An insert writes
//   the new slot, then sifts down every internal node; each sift level makes
//   three reads of node and children through the one RAM read port, plus
//   two writes on a swap. A full rebuild swaps fewer than N times.
//   A traverse visits each node up to three times.
// Reset clears the entry count; the store needs no clearing pass.
// A stalled receiver holds the output register and the walk waits for it.
module max_heap_rebuild_and_traverse #(
  parameter int HEAP_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[31:0], payload[63:32]
  input  logic [2:0]  s_axis_tuser,   // func[0], order[2:1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // key_res[31:0], payload_res[63:32], position[69:64]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast
);

  localparam int AW = (HEAP_SLOTS > 1) ? $clog2(HEAP_SLOTS) : 1;
  localparam int CW = $clog2(HEAP_SLOTS + 1);
  localparam int IW = AW + 2;
  localparam int EW = mhrt_pkg::ENT_W;
  localparam int KW = mhrt_pkg::KEY_W;

  mhrt_pkg::state_t state, state_next;

  logic [CW-1:0]  count;
  logic [AW-1:0]  base;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  big;
  logic [EW-1:0]  node;
  logic [EW-1:0]  bigw;
  logic [AW-1:0]  cur;
  mhrt_pkg::dir_t dir;
  mhrt_pkg::order_t ord;
  logic [EW-1:0]  in_ent;
  mhrt_pkg::kind_t resp_kind;
  logic           hold_valid;
  logic [EW-1:0]  hold_ent;
  logic [AW-1:0]  hold_pos;

  logic           out_valid;
  logic           out_last;
  mhrt_pkg::kind_t out_kind;
  logic [EW-1:0]  out_ent;
  logic [AW-1:0]  out_pos;

  // RAM signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  mhrt_ram #(.WIDTH(EW), .DEPTH(HEAP_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // child indexes and bounds
  logic [IW-1:0] cnt_w, l_w, r_w, cl_w, cr_w;
  logic          s_acc, out_free, stall, full;
  assign cnt_w = IW'(count);
  assign l_w   = IW'({idx, 1'b1});
  assign r_w   = IW'({idx, 1'b0}) + IW'(2);
  assign cl_w  = IW'({cur, 1'b1});
  assign cr_w  = IW'({cur, 1'b0}) + IW'(2);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign stall    = hold_valid && !out_free;
  assign full     = (count == CW'(HEAP_SLOTS));

  // one shared key compare: node against left in S_SR, winner against right in S_SC
  logic [KW-1:0] cmp_a;
  logic          key_gt;
  logic          left_win, right_win, sift_done;
  logic [AW-1:0] big_fin;
  assign cmp_a     = (state == mhrt_pkg::S_SR) ? node[KW-1:0] : bigw[KW-1:0];
  assign key_gt    = ($signed(cmp_a) < $signed(ram_rdata[KW-1:0]));
  assign left_win  = (l_w < cnt_w) && key_gt;
  assign right_win = (r_w < cnt_w) && key_gt;
  assign big_fin   = right_win ? r_w[AW-1:0] : big;
  assign sift_done = (big_fin == idx);

  // walk: emit decision and next position
  logic          w_emit, mv_done;
  logic [AW-1:0] mv_cur;
  mhrt_pkg::dir_t mv_dir;
  always_comb begin
    w_emit = (ord == mhrt_pkg::ORD_ARRAY) ||
             (dir == mhrt_pkg::D_DOWN  && ord == mhrt_pkg::ORD_PRE) ||
             (dir == mhrt_pkg::D_LEFT  && ord == mhrt_pkg::ORD_IN) ||
             (dir == mhrt_pkg::D_RIGHT && ord == mhrt_pkg::ORD_POST);
    mv_cur  = cur;
    mv_dir  = dir;
    mv_done = 1'b0;
    if (ord == mhrt_pkg::ORD_ARRAY) begin
      mv_cur  = cur + AW'(1);
      mv_done = (IW'(cur) + IW'(1) == cnt_w);
    end else begin
      unique case (dir)
        mhrt_pkg::D_DOWN: begin
          if (cl_w < cnt_w) begin
            mv_cur = cl_w[AW-1:0];
          end else begin
            mv_dir = mhrt_pkg::D_LEFT;
          end
        end
        mhrt_pkg::D_LEFT: begin
          if (cr_w < cnt_w) begin
            mv_cur = cr_w[AW-1:0];
            mv_dir = mhrt_pkg::D_DOWN;
          end else begin
            mv_dir = mhrt_pkg::D_RIGHT;
          end
        end
        default: begin
          if (cur == '0) begin
            mv_done = 1'b1;
          end else begin
            mv_cur = (cur - AW'(1)) >> 1;
            mv_dir = cur[0] ? mhrt_pkg::D_LEFT : mhrt_pkg::D_RIGHT;
          end
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mhrt_pkg::S_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser[0] == 1'(mhrt_pkg::FUNC_INSERT)) begin
            state_next = full ? mhrt_pkg::S_RESP : mhrt_pkg::S_INS;
          end else begin
            state_next = (count == '0) ? mhrt_pkg::S_RESP : mhrt_pkg::S_WNODE;
          end
        end
      end
      mhrt_pkg::S_INS:  state_next = (count == '0) ? mhrt_pkg::S_RESP : mhrt_pkg::S_SN;
      mhrt_pkg::S_SN:   state_next = mhrt_pkg::S_SL;
      mhrt_pkg::S_SL:   state_next = mhrt_pkg::S_SR;
      mhrt_pkg::S_SR:   state_next = mhrt_pkg::S_SC;
      mhrt_pkg::S_SC: begin
        if (!sift_done) begin
          state_next = mhrt_pkg::S_SW1;
        end else begin
          state_next = (base == '0) ? mhrt_pkg::S_RESP : mhrt_pkg::S_SN;
        end
      end
      mhrt_pkg::S_SW1:  state_next = mhrt_pkg::S_SW2;
      mhrt_pkg::S_SW2:  state_next = mhrt_pkg::S_SN;
      mhrt_pkg::S_WNODE: begin
        if (w_emit) begin
          state_next = mhrt_pkg::S_WDATA;
        end else if (mv_done) begin
          state_next = mhrt_pkg::S_FLUSH;
        end
      end
      mhrt_pkg::S_WDATA: begin
        if (!stall) begin
          state_next = mv_done ? mhrt_pkg::S_FLUSH : mhrt_pkg::S_WNODE;
        end
      end
      mhrt_pkg::S_FLUSH, mhrt_pkg::S_RESP: begin
        if (out_free) begin
          state_next = mhrt_pkg::S_IDLE;
        end
      end
      default: state_next = mhrt_pkg::S_IDLE;
    endcase
  end

  // RAM control outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = bigw;
    ram_raddr = idx;
    unique case (state)
      mhrt_pkg::S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = count[AW-1:0];
        ram_wdata = in_ent;
      end
      mhrt_pkg::S_SW1: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = bigw;
      end
      mhrt_pkg::S_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = big;
        ram_wdata = node;
      end
      mhrt_pkg::S_SL:    ram_raddr = l_w[AW-1:0];
      mhrt_pkg::S_SR:    ram_raddr = r_w[AW-1:0];
      mhrt_pkg::S_WNODE, mhrt_pkg::S_WDATA: ram_raddr = cur;
      default: ram_raddr = idx;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mhrt_pkg::S_IDLE;
      count      <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mhrt_pkg::S_INS) begin
        count <= count + CW'(1);
      end
      if (state == mhrt_pkg::S_IDLE) begin
        hold_valid <= 1'b0;
      end else if (state == mhrt_pkg::S_WDATA && !stall) begin
        hold_valid <= 1'b1;
      end
      if ((state == mhrt_pkg::S_WDATA && !stall && hold_valid) ||
          ((state == mhrt_pkg::S_FLUSH || state == mhrt_pkg::S_RESP) && out_free)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      mhrt_pkg::S_IDLE: begin
        in_ent <= {s_axis_tdata[63:32], s_axis_tdata[31:0]};
        ord    <= mhrt_pkg::order_t'(s_axis_tuser[2:1]);
        cur    <= '0;
        dir    <= mhrt_pkg::D_DOWN;
        if (s_axis_tuser[0] == 1'(mhrt_pkg::FUNC_INSERT)) begin
          resp_kind <= full ? mhrt_pkg::K_OVF : mhrt_pkg::K_INS;
        end else begin
          resp_kind <= mhrt_pkg::K_EMPTY;
        end
      end
      mhrt_pkg::S_INS: begin
        // first internal node of the grown heap: (count+1)/2 - 1
        base <= AW'((IW'(count) + IW'(1)) / 2 - IW'(1));
        idx  <= AW'((IW'(count) + IW'(1)) / 2 - IW'(1));
      end
      mhrt_pkg::S_SL: begin
        node <= ram_rdata;
      end
      mhrt_pkg::S_SR: begin
        big  <= left_win ? l_w[AW-1:0] : idx;
        bigw <= left_win ? ram_rdata : node;
      end
      mhrt_pkg::S_SC: begin
        big <= big_fin;
        if (right_win) begin
          bigw <= ram_rdata;
        end
        if (sift_done && base != '0) begin
          base <= base - AW'(1);
          idx  <= base - AW'(1);
        end
      end
      mhrt_pkg::S_SW2: begin
        idx <= big;
      end
      mhrt_pkg::S_WNODE: begin
        if (!w_emit) begin
          cur <= mv_cur;
          dir <= mv_dir;
        end
      end
      mhrt_pkg::S_WDATA: begin
        if (!stall) begin
          hold_ent <= ram_rdata;
          hold_pos <= cur;
          cur      <= mv_cur;
          dir      <= mv_dir;
        end
      end
      default: begin
      end
    endcase
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == mhrt_pkg::S_WDATA && !stall && hold_valid) begin
      out_kind <= mhrt_pkg::K_ENT;
      out_ent  <= hold_ent;
      out_pos  <= hold_pos;
      out_last <= 1'b0;
    end else if (state == mhrt_pkg::S_FLUSH && out_free) begin
      out_kind <= mhrt_pkg::K_ENT;
      out_ent  <= hold_ent;
      out_pos  <= hold_pos;
      out_last <= 1'b1;
    end else if (state == mhrt_pkg::S_RESP && out_free) begin
      out_kind <= resp_kind;
      out_ent  <= '0;
      out_pos  <= '0;
      out_last <= 1'b1;
    end
  end

  assign s_axis_tready = (state == mhrt_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {2'b00, mhrt_pkg::POS_W'(out_pos), out_ent};

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HEAP_SLOTS))
    else $error("entry count beyond heap size");

  a_hold_clear_idle: assert property (@(posedge clk) disable iff (rst)
    state == mhrt_pkg::S_IDLE |=> !hold_valid)
    else $error("stale walk result after idle");

  a_full_unchanged: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_axis_tuser[0] == 1'(mhrt_pkg::FUNC_INSERT) && full) |=> ##1 $stable(count))
    else $error("overflow insert changed the heap");

  a_walk_needs_entries: assert property (@(posedge clk) disable iff (rst)
    state == mhrt_pkg::S_WNODE |-> count != '0)
    else $error("walk on empty heap");
`endif

endmodule
